// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of this block, bpb_checker.sv.
// Include by bare file name; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BPB_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define BPB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/bpb_pkg.sv =====
// Shared constants and types for the byte permutation builder.
// No dependencies; compile first.
package bpb_pkg;

  localparam int LIST_SIZE  = 256;
  localparam int LIST_AW    = 8;
  localparam int NUM_PASSES = 8;

  localparam int DEFAULT_BLOCK_BYTES   = 2048;
  localparam int DEFAULT_SEGMENT_BYTES = 256;

  localparam int OPCODE_W = 2;
  localparam int BYTE_W   = 8;
  localparam int ADDR_W   = 11;

  typedef enum logic [OPCODE_W-1:0] {
    OP_STORE = 2'd0,
    OP_BUILD = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

endpackage

// ===== rtl/core/bpb_cmd_if.sv =====
// Command channel: valid/ready handshake plus the request payload.
// Depends on bpb_pkg.
interface bpb_cmd_if import bpb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [BYTE_W-1:0]   entropy_byte;
  logic [ADDR_W-1:0]   byte_address;
  logic [LIST_AW-1:0]  entry_position;

  modport source (output valid, output opcode, output entropy_byte,
                  output byte_address, output entry_position, input ready);
  modport sink   (input valid, input opcode, input entropy_byte,
                  input byte_address, input entry_position, output ready);
endinterface

// ===== rtl/core/bpb_rsp_if.sv =====
// Response channel: valid/ready handshake plus the list entry value.
// Depends on bpb_pkg.
interface bpb_rsp_if import bpb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LIST_AW-1:0] entry_value;

  modport source (output valid, output entry_value, input ready);
  modport sink   (input valid, input entry_value, output ready);
endinterface

// ===== rtl/core/bpb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bpb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/byte_permutation_builder_core.sv =====
// Store and no-op are answered from S_IDLE; a read waits in S_RD_RESP for the list RAM.
// Build: each pass runs S_PASS_INIT, then S_DRAW and S_CHECK per entropy byte drawn and
// S_READ_B, S_WRITE_A and S_WRITE_B per swap, then S_PASS_END; running out of bytes goes
// from S_DRAW straight to S_PASS_END, dropping the rest of that pass. One response
// per request. Reset: synchronous; the list reads as the identity through
// per-entry valid bits, entropy store is undefined until written. No clearing pass.
module byte_permutation_builder_core import bpb_pkg::*; #(
  parameter int BLOCK_BYTES   = DEFAULT_BLOCK_BYTES,
  parameter int SEGMENT_BYTES = DEFAULT_SEGMENT_BYTES
) (
  input logic        clk,
  input logic        rst,
  bpb_cmd_if.sink    cmd,
  bpb_rsp_if.source  rsp
);

  localparam int EAW      = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
  localparam int SPAN_MAX = (NUM_PASSES * SEGMENT_BYTES > BLOCK_BYTES) ?
                            NUM_PASSES * SEGMENT_BYTES : BLOCK_BYTES;
  localparam int CW       = $clog2(SPAN_MAX + SEGMENT_BYTES + 1);
  localparam int AXW      = (CW > ADDR_W) ? CW : ADDR_W;
  localparam int PASS_W   = $clog2(NUM_PASSES);
  localparam int REM_W    = LIST_AW + 1;

  localparam logic [PASS_W-1:0] LAST_PASS = PASS_W'(NUM_PASSES - 1);
  localparam logic [CW-1:0]     BLK       = CW'(BLOCK_BYTES);
  localparam logic [CW-1:0]     SEG       = CW'(SEGMENT_BYTES);

  typedef enum logic [3:0] {
    S_IDLE, S_RD_RESP, S_PASS_INIT, S_DRAW, S_CHECK,
    S_READ_B, S_WRITE_A, S_WRITE_B, S_PASS_END
  } state_t;

  state_t               state;
  logic [PASS_W-1:0]    pass_idx;
  logic [CW-1:0]        seg_lo;
  logic [CW-1:0]        start_q;
  logic [CW-1:0]        cursor;
  logic [LIST_AW-1:0]   pos;
  logic [REM_W-1:0]     remaining;
  logic [LIST_AW-1:0]   mask;
  logic [LIST_AW-1:0]   other;
  logic [LIST_AW-1:0]   val_a;

  logic                 list_valid [LIST_SIZE];
  logic                 rd_valid_q;
  logic [LIST_AW-1:0]   rd_addr_q;

  logic                 out_valid_q;
  logic [LIST_AW-1:0]   out_data_q;
  logic                 skid_full;
  logic [LIST_AW-1:0]   skid_data;

  // Request decode and entropy store write
  logic                 cmd_acc;
  opcode_t              op;
  logic [AXW-1:0]       addr_ext;
  logic                 store_ok;
  logic                 e_we;
  logic [EAW-1:0]       e_waddr;
  logic [CW-1:0]        cursor_dec;
  logic [EAW-1:0]       e_raddr;
  logic [BYTE_W-1:0]    e_rdata;

  // Shuffle datapath
  logic [CW-1:0]        seg_hi;
  logic [CW-1:0]        pass_start;
  logic [CW-1:0]        pass_ceil;
  logic [LIST_AW-1:0]   off;
  logic                 draw_ok;
  logic [REM_W-1:0]     rem_dec;
  logic                 rem_pow2;

  // List RAM ports
  logic                 l_we;
  logic [LIST_AW-1:0]   l_waddr;
  logic [LIST_AW-1:0]   l_wdata;
  logic [LIST_AW-1:0]   l_raddr;
  logic [LIST_AW-1:0]   l_rdata;
  logic [LIST_AW-1:0]   list_rd;

  // Response push
  logic                 push;
  logic [LIST_AW-1:0]   push_data;
  logic                 out_free;

  assign cmd.ready = (state == S_IDLE) && !skid_full;
  assign cmd_acc   = cmd.valid && cmd.ready;
  assign op        = opcode_t'(cmd.opcode);

  assign addr_ext  = AXW'(cmd.byte_address);
  assign store_ok  = addr_ext < AXW'(BLOCK_BYTES);
  assign e_we      = cmd_acc && (op == OP_STORE) && store_ok;
  assign e_waddr   = addr_ext[EAW-1:0];

  assign cursor_dec = cursor - CW'(1);
  assign e_raddr    = cursor_dec[EAW-1:0];

  assign seg_hi     = seg_lo + SEG;
  assign pass_start = (seg_lo > BLK) ? BLK : seg_lo;
  assign pass_ceil  = (pass_idx == LAST_PASS) ? BLK : ((seg_hi > BLK) ? BLK : seg_hi);

  assign off      = e_rdata & mask;
  assign draw_ok  = {1'b0, off} < remaining;
  assign rem_dec  = remaining - REM_W'(1);
  assign rem_pow2 = (rem_dec & (rem_dec - REM_W'(1))) == '0;

  // Entries never written since the last clear read as their own index
  assign list_rd = rd_valid_q ? l_rdata : rd_addr_q;

  always_comb begin
    case (state)
      S_IDLE:   l_raddr = cmd.entry_position;
      S_READ_B: l_raddr = other;
      default:  l_raddr = pos;
    endcase
  end

  assign l_we    = (state == S_WRITE_A) || (state == S_WRITE_B);
  assign l_waddr = (state == S_WRITE_A) ? pos : other;
  assign l_wdata = (state == S_WRITE_A) ? list_rd : val_a;

  assign push = (cmd_acc && ((op == OP_STORE) || (op == OP_NOP))) ||
                (state == S_RD_RESP) ||
                ((state == S_PASS_END) && (pass_idx == LAST_PASS));
  assign push_data = (state == S_RD_RESP) ? list_rd : '0;
  assign out_free  = !out_valid_q || rsp.ready;

  assign rsp.valid       = out_valid_q;
  assign rsp.entry_value = out_data_q;

  bpb_ram #(.WIDTH(BYTE_W), .DEPTH(BLOCK_BYTES)) u_entropy_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (cmd.entropy_byte),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  bpb_ram #(.WIDTH(LIST_AW), .DEPTH(LIST_SIZE)) u_list_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid_q <= 1'b0;
      skid_full   <= 1'b0;
      for (int i = 0; i < LIST_SIZE; i++) begin
        list_valid[i] <= 1'b0;
      end
    end else begin
      rd_valid_q <= list_valid[l_raddr];
      rd_addr_q  <= l_raddr;

      if (l_we) begin
        list_valid[l_waddr] <= 1'b1;
      end

      case (state)
        S_IDLE: begin
          if (cmd_acc) begin
            case (op)
              OP_READ: begin
                state <= S_RD_RESP;
              end
              OP_BUILD: begin
                // back to identity by clearing every valid bit
                for (int i = 0; i < LIST_SIZE; i++) begin
                  list_valid[i] <= 1'b0;
                end
                pass_idx <= '0;
                seg_lo   <= '0;
                state    <= S_PASS_INIT;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_RD_RESP: begin
          state <= S_IDLE;
        end
        S_PASS_INIT: begin
          start_q   <= pass_start;
          cursor    <= pass_ceil;
          pos       <= '0;
          remaining <= REM_W'(LIST_SIZE);
          mask      <= '1;
          state     <= S_DRAW;
        end
        S_DRAW: begin
          // out of bytes (or empty segment): drop the rest of this pass
          if (cursor <= start_q) begin
            state <= S_PASS_END;
          end else begin
            cursor <= cursor_dec;
            state  <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (draw_ok) begin
            other <= pos + off;
            state <= S_READ_B;
          end else begin
            state <= S_DRAW;
          end
        end
        S_READ_B: begin
          val_a <= list_rd;
          state <= S_WRITE_A;
        end
        S_WRITE_A: begin
          state <= S_WRITE_B;
        end
        S_WRITE_B: begin
          pos       <= pos + LIST_AW'(1);
          remaining <= rem_dec;
          if (rem_pow2) begin
            mask <= LIST_AW'(rem_dec - REM_W'(1));
          end
          state <= (rem_dec == REM_W'(1)) ? S_PASS_END : S_DRAW;
        end
        S_PASS_END: begin
          if (pass_idx == LAST_PASS) begin
            state <= S_IDLE;
          end else begin
            pass_idx <= pass_idx + PASS_W'(1);
            seg_lo   <= seg_hi;
            state    <= S_PASS_INIT;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // Output register with one skid entry behind it
      if (out_free) begin
        if (skid_full) begin
          out_valid_q <= 1'b1;
          out_data_q  <= skid_data;
          skid_full   <= push;
          skid_data   <= push_data;
        end else if (push) begin
          out_valid_q <= 1'b1;
          out_data_q  <= push_data;
        end else begin
          out_valid_q <= 1'b0;
        end
      end else if (push) begin
        skid_full <= 1'b1;
        skid_data <= push_data;
      end
    end
  end

endmodule

// ===== rtl/core/bpb_checker.sv =====
// Port-level checks for byte_permutation_builder_core, attached by bind.
// Depends on bpb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bpb_checker import bpb_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                cmd_valid,
  input logic                cmd_ready,
  input logic [OPCODE_W-1:0] cmd_opcode,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [LIST_AW-1:0]  rsp_entry_value
);

  logic cmd_acc;
  assign cmd_acc = cmd_valid && cmd_ready;

  // a build holds off further requests while it runs
  `BPB_ASSERT_NEXT(build_blocks_cmd, clk, rst, cmd_acc && (cmd_opcode == OP_BUILD), !cmd_ready)

  // a read needs the list RAM latency before the next request
  `BPB_ASSERT_NEXT(read_blocks_cmd, clk, rst, cmd_acc && (cmd_opcode == OP_READ), !cmd_ready)

  // store and no-op answer zero right away into an empty output
  `BPB_ASSERT_NEXT(store_nop_zero, clk, rst, cmd_acc && !rsp_valid && ((cmd_opcode == OP_STORE) || (cmd_opcode == OP_NOP)), rsp_valid && (rsp_entry_value == '0))

  `BPB_ASSERT_NEXT(rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_entry_value))

endmodule

bind byte_permutation_builder_core bpb_checker u_bpb_checker (
  .clk             (clk),
  .rst             (rst),
  .cmd_valid       (cmd.valid),
  .cmd_ready       (cmd.ready),
  .cmd_opcode      (cmd.opcode),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_entry_value (rsp.entry_value)
);

// ===== tb/byte_permutation_builder_core_test.sv =====
// Self-checking bench for byte_permutation_builder_core: loads entropy, builds and reads back
// permutations, predicts every response in a scoreboard class with its own shuffle model.
// Depends on bpb_pkg, bpb_cmd_if, bpb_rsp_if and the core RTL.
module byte_permutation_builder_core_test;
  import bpb_pkg::*;

  localparam int BLOCK_BYTES   = DEFAULT_BLOCK_BYTES;
  localparam int SEGMENT_BYTES = DEFAULT_SEGMENT_BYTES;
  localparam int RANDOM_ITEMS  = 650;
  localparam int CALM_ITEMS    = 100;
  localparam int MAX_BUILDS    = 24;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 20;
  localparam int CYCLE_LIMIT   = 2_000_000;

  class perm_scoreboard;
    bit [BYTE_W-1:0]  entropy_mem [BLOCK_BYTES];
    bit [LIST_AW-1:0] perm_list [LIST_SIZE];
    bit [LIST_AW-1:0] pending_values [$];
    int unsigned      mismatch_count;

    function new();
      mismatch_count = 0;
      load_identity();
    endfunction

    function void load_identity();
      foreach (perm_list[i]) perm_list[i] = LIST_AW'(i);
    endfunction

    // One shuffle pass over the list, drawing from store[lo..hi-1] top down.
    function void shuffle_segment(int unsigned lo, int unsigned hi);
      int unsigned      cursor = hi;
      int unsigned      pos = 0;
      int unsigned      left = LIST_SIZE;
      int unsigned      mask = LIST_SIZE - 1;
      int unsigned      off = 0;
      int unsigned      other;
      bit               drawn;
      bit [LIST_AW-1:0] hold;
      while (left > 1) begin
        drawn = 1'b0;
        while (!drawn) begin
          if (cursor <= lo) return;
          cursor--;
          off = entropy_mem[cursor] & mask;
          drawn = (off < left);
        end
        other = (pos + off) % LIST_SIZE;
        hold = perm_list[pos % LIST_SIZE];
        perm_list[pos % LIST_SIZE] = perm_list[other];
        perm_list[other] = hold;
        pos++;
        left--;
        if ((left & (left - 1)) == 0) mask = left - 1;
      end
    endfunction

    function void build_list();
      int unsigned lo;
      int unsigned hi;
      load_identity();
      for (int k = 0; k < NUM_PASSES; k++) begin
        lo = (k * SEGMENT_BYTES > BLOCK_BYTES) ? BLOCK_BYTES : k * SEGMENT_BYTES;
        hi = ((k + 1) * SEGMENT_BYTES > BLOCK_BYTES) ? BLOCK_BYTES : (k + 1) * SEGMENT_BYTES;
        if (k == NUM_PASSES - 1) hi = BLOCK_BYTES;
        if (lo < hi) shuffle_segment(lo, hi);
      end
    endfunction

    function void note_request(opcode_t op, bit [BYTE_W-1:0] data, bit [ADDR_W-1:0] addr,
                               bit [LIST_AW-1:0] pos);
      bit [LIST_AW-1:0] value = '0;
      case (op)
        OP_STORE: if (addr < BLOCK_BYTES) entropy_mem[addr] = data;
        OP_BUILD: build_list();
        OP_READ:  value = perm_list[pos];
        default:  ;
      endcase
      pending_values.push_back(value);
    endfunction

    function void log_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch: %s", what);
    endfunction

    function void check_result(bit [LIST_AW-1:0] got);
      bit [LIST_AW-1:0] want;
      if (pending_values.size() == 0) begin
        log_mismatch($sformatf("entry_value %0d with no request pending", got));
      end else begin
        want = pending_values.pop_front();
        if (got !== want)
          log_mismatch($sformatf("entry_value expected %0d actual %0d", want, got));
      end
    endfunction

    function int unsigned outstanding();
      return pending_values.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  bit          allow_idle = 1'b1;
  bit          hold_request = 1'b0;
  int unsigned cycle_count = 0;

  perm_scoreboard sb = new();

  bpb_cmd_if cmd();
  bpb_rsp_if rsp();

  byte_permutation_builder_core u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Note the request before checking, in case a response shares its edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (cmd.valid && cmd.ready)
        sb.note_request(opcode_t'(cmd.opcode), cmd.entropy_byte, cmd.byte_address,
                        cmd.entry_position);
      if (rsp.valid && rsp.ready) sb.check_result(rsp.entry_value);
    end
  end

  // Response side: random stall bursts, one long hold-off on request.
  initial begin
    rsp.ready <= 1'b0;
    forever begin
      if (hold_request) begin
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else if (allow_idle && $urandom_range(0, 5) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        rsp.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Present one request, optionally after an idle burst; return at its accepting edge.
  task automatic send_request(input opcode_t op, input logic [BYTE_W-1:0] data,
                              input logic [ADDR_W-1:0] addr, input logic [LIST_AW-1:0] pos);
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      cmd.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    cmd.valid          <= 1'b1;
    cmd.opcode         <= op;
    cmd.entropy_byte   <= data;
    cmd.byte_address   <= addr;
    cmd.entry_position <= pos;
    do @(posedge clk); while (!cmd.ready);
  endtask

  initial begin
    int unsigned      builds;
    int unsigned      pick;
    opcode_t          op;
    logic [BYTE_W-1:0] data;

    builds = 0;
    cmd.valid          <= 1'b0;
    cmd.opcode         <= OP_NOP;
    cmd.entropy_byte   <= '0;
    cmd.byte_address   <= '0;
    cmd.entry_position <= '0;
    rst <= 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // List reads as the identity before any build; field extremes on read, no-op and store.
    send_request(OP_READ, 8'hff, 11'h7ff, 8'd0);
    send_request(OP_READ, 8'h00, 11'h000, 8'd255);
    send_request(OP_NOP, 8'hff, 11'h7ff, 8'hff);
    send_request(OP_NOP, 8'h00, 11'h000, 8'h00);
    send_request(OP_STORE, 8'hff, 11'h7ff, 8'hff);
    send_request(OP_STORE, 8'h00, 11'h000, 8'h00);
    send_request(OP_READ, 8'h5a, 11'h2a5, 8'd128);

    // Fill the whole store before the first build: zeros let pass 0 finish,
    // all-ones starve pass 1 after one swap, the rest is random.
    for (int a = 0; a < BLOCK_BYTES; a++) begin
      if (a < SEGMENT_BYTES) data = 8'h00;
      else if (a < 2 * SEGMENT_BYTES) data = 8'hff;
      else data = BYTE_W'($urandom_range(0, 255));
      send_request(OP_STORE, data, ADDR_W'(a), LIST_AW'($urandom_range(0, 255)));
    end
    send_request(OP_BUILD, 8'hff, 11'h7ff, 8'hff);
    send_request(OP_READ, 8'h00, 11'h000, 8'd0);
    send_request(OP_READ, 8'h00, 11'h000, 8'd1);
    send_request(OP_READ, 8'hff, 11'h7ff, 8'd254);
    send_request(OP_READ, 8'hff, 11'h7ff, 8'd255);
    for (int i = 0; i < 6; i++)
      send_request(OP_READ, BYTE_W'($urandom_range(0, 255)), ADDR_W'($urandom_range(0, 2047)),
                   LIST_AW'($urandom_range(0, 255)));
    send_request(OP_BUILD, 8'h00, 11'h000, 8'h00);
    send_request(OP_READ, 8'h00, 11'h000, 8'd0);

    // Random traffic; the response side starts with a long hold-off.
    hold_request = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - CALM_ITEMS) allow_idle = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 3 && builds < MAX_BUILDS) begin
        op = OP_BUILD;
        builds++;
      end else if (pick < 50) begin
        op = OP_STORE;
      end else if (pick < 90) begin
        op = OP_READ;
      end else begin
        op = OP_NOP;
      end
      data = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
      send_request(op, data, ADDR_W'($urandom_range(0, 2047)), LIST_AW'($urandom_range(0, 255)));
    end
    cmd.valid <= 1'b0;

    // Let the monitor note the last request before counting what is still due.
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.outstanding() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
